### hw/rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap priority queue: request
// and response payloads, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int KEY_W         = 32;
   localparam int CNT_W         = 11;
   localparam int DEPTH_DEFAULT = 1024;

   localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                    func;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] removed_key;
      logic [1:0]              status;
      logic signed [KEY_W-1:0] min_key;
      logic [CNT_W-1:0]        entry_count;
      logic                    is_empty;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic load_last;
      logic up_read;
      logic up_cmp;
      logic down_read;
      logic down_cmp;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic refuse;
      logic is_insert;
      logic last_gone;
      logic at_root;
      logic leaf;
      logic up_move;
      logic down_move;
      logic rsp_free;
   } sts_type;

endpackage

### hw/rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller of the heap queue: sequences the check, sift-up and sift-down
// steps of one request and the hand-over of its response.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmhq_pkg::sts_type sts,
   output bmhq_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CHECK     = 8'b0000_0010,
      ST_LOAD_LAST = 8'b0000_0100,
      ST_UP_READ   = 8'b0000_1000,
      ST_UP_CMP    = 8'b0001_0000,
      ST_DOWN_READ = 8'b0010_0000,
      ST_DOWN_CMP  = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            priority if (sts.refuse) begin
               state_in = ST_FINISH;
            end else if (sts.is_insert) begin
               state_in = ST_UP_READ;
            end else if (sts.last_gone) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LOAD_LAST;
            end
         end
         ST_LOAD_LAST: begin
            cmd.load_last = 1'b1;
            state_in      = ST_DOWN_READ;
         end
         ST_UP_READ: begin
            cmd.up_read = 1'b1;
            state_in    = sts.at_root ? ST_FINISH : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            cmd.up_cmp = 1'b1;
            state_in   = sts.up_move ? ST_UP_READ : ST_FINISH;
         end
         ST_DOWN_READ: begin
            cmd.down_read = 1'b1;
            state_in      = sts.leaf ? ST_FINISH : ST_DOWN_CMP;
         end
         ST_DOWN_CMP: begin
            cmd.down_cmp = 1'b1;
            state_in     = sts.down_move ? ST_DOWN_READ : ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Datapath of the heap queue: heap memory with one write and two read ports,
// moving-key and position registers, count, capacity and response register.
// ----------------------------------------------------------------------------
module bmhq_datapath #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bmhq_pkg::req_type              req_data,
   input  logic                           csr_wr_en,
   input  logic [bmhq_pkg::CNT_W-1:0]     csr_wr_data,
   input  bmhq_pkg::cmd_type              cmd,
   output bmhq_pkg::sts_type              sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bmhq_pkg::rsp_type              rsp_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = ((bmhq_pkg::CNT_W > ADDR_W + 1) ? bmhq_pkg::CNT_W : ADDR_W + 1) + 1;
   localparam int KW     = bmhq_pkg::KEY_W;
   localparam int CW     = bmhq_pkg::CNT_W;

   logic signed [KW-1:0] mem [DEPTH];

   logic                 func_ff,    func_in;
   logic signed [KW-1:0] key_ff,     key_in;
   logic signed [KW-1:0] cur_ff,     cur_in;
   logic [ADDR_W-1:0]    pos_ff,     pos_in;
   logic [CW-1:0]        count_ff,   count_in;
   logic [CW-1:0]        cap_ff,     cap_in;
   logic signed [KW-1:0] root_ff,    root_in;
   logic signed [KW-1:0] removed_ff, removed_in;
   logic [1:0]           status_ff,  status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::rsp_type    rsp_ff,     rsp_in;
   logic signed [KW-1:0] rd0_ff;
   logic signed [KW-1:0] rd1_ff;

   logic                 we;
   logic [ADDR_W-1:0]    waddr;
   logic signed [KW-1:0] wdata;
   logic [ADDR_W-1:0]    raddr0;
   logic [ADDR_W-1:0]    raddr1;

   logic [IDX_W-1:0]     n_ext;
   logic [IDX_W-1:0]     cap_ext;
   logic [IDX_W-1:0]     limit;
   logic [IDX_W-1:0]     child_l;
   logic [IDX_W-1:0]     child_r;
   logic [ADDR_W-1:0]    parent;
   logic                 pick_right;
   logic signed [KW-1:0] pick_key;
   logic [IDX_W-1:0]     pick_idx;

   // status towards the controller
   always_comb begin
      n_ext      = IDX_W'(count_ff);
      cap_ext    = IDX_W'(cap_ff);
      limit      = (cap_ext > IDX_W'(DEPTH)) ? IDX_W'(DEPTH) : cap_ext;
      child_l    = (IDX_W'(pos_ff) << 1) + IDX_W'(1);
      child_r    = child_l + IDX_W'(1);
      parent     = (pos_ff - ADDR_W'(1)) >> 1;
      pick_right = (child_r < n_ext) && (rd1_ff < rd0_ff);
      pick_key   = pick_right ? rd1_ff : rd0_ff;
      pick_idx   = pick_right ? child_r : child_l;

      sts.is_insert = (func_ff == bmhq_pkg::FUNC_INSERT);
      sts.refuse    = sts.is_insert ? (n_ext >= limit) : (count_ff == '0);
      sts.last_gone = (count_ff == CW'(1));
      sts.at_root   = (pos_ff == '0);
      sts.leaf      = (child_l >= n_ext);
      sts.up_move   = (cur_ff < rd0_ff);
      sts.down_move = (pick_key < cur_ff);
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // register updates and memory port selection
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      we           = 1'b0;
      waddr        = pos_ff;
      wdata        = cur_ff;
      raddr0       = '0;
      raddr1       = '0;

      if (cmd.capture) begin
         func_in    = req_data.func;
         key_in     = req_data.key;
         removed_in = '0;
         status_in  = bmhq_pkg::STATUS_DONE;
      end

      if (cmd.check) begin
         priority if (sts.refuse) begin
            status_in = sts.is_insert ? bmhq_pkg::STATUS_FULL : bmhq_pkg::STATUS_EMPTY;
         end else if (sts.is_insert) begin
            cur_in   = key_ff;
            pos_in   = ADDR_W'(count_ff);
            count_in = count_ff + CW'(1);
         end else begin
            removed_in = root_ff;
            count_in   = count_ff - CW'(1);
            raddr0     = ADDR_W'(count_in);
            pos_in     = '0;
         end
      end

      if (cmd.load_last) begin
         cur_in = rd0_ff;
      end

      if (cmd.up_read) begin
         if (sts.at_root) begin
            we = 1'b1;
         end else begin
            raddr0 = parent;
         end
      end

      if (cmd.up_cmp) begin
         we = 1'b1;
         if (sts.up_move) begin
            wdata  = rd0_ff;
            pos_in = parent;
         end
      end

      if (cmd.down_read) begin
         if (sts.leaf) begin
            we = 1'b1;
         end else begin
            raddr0 = ADDR_W'(child_l);
            raddr1 = ADDR_W'(child_r);
         end
      end

      if (cmd.down_cmp) begin
         we = 1'b1;
         if (sts.down_move) begin
            wdata  = pick_key;
            pos_in = ADDR_W'(pick_idx);
         end
      end

      root_in = (we && (waddr == '0)) ? wdata : root_ff;

      if (cmd.load_rsp) begin
         rsp_valid_in       = 1'b1;
         rsp_in.removed_key = removed_ff;
         rsp_in.status      = status_ff;
         rsp_in.min_key     = (count_ff != '0) ? root_ff : '0;
         rsp_in.entry_count = count_ff;
         rsp_in.is_empty    = (count_ff == '0);
      end
   end

   // heap store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= bmhq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      key_ff     <= key_in;
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      root_ff    <= root_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      IDX_W'(count_ff) <= IDX_W'(DEPTH))
      else $error("entry count beyond store depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (IDX_W'(waddr) < IDX_W'(count_ff)))
      else $error("heap write outside stored entries");

   a_refuse_holds_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && sts.refuse) |=> $stable(count_ff))
      else $error("refused request changed the count");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

endmodule

### hw/rtl/binary_min_heap_queue.sv
// Steps: insert checks, then climbs a level per parent read and compare until
//   the root or no move; extract checks, loads the last key, then sinks a level
//   per read and compare; refusals and last-key extracts end after the check.
// Throughput: one request at a time, the next accepted the cycle after the
//   response is registered; a pending response does not block acceptance.
// Reset: count cleared, capacity limit 1024, store contents left undefined.
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of signed keys on a binary min-heap: insert and extract-min
// requests, each answered by one response with the new minimum and count.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bmhq_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bmhq_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [bmhq_pkg::CNT_W-1:0] csr_wr_data
);

   bmhq_pkg::cmd_type cmd;
   bmhq_pkg::sts_type sts;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmhq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
